// ----- sv/ppg_pkg.sv -----
// shared types, constants and the sine table builder of the plasma pattern generator
package ppg_pkg;

  localparam int TABLE_SIZE   = 512;
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int PHASE_W      = $clog2(TABLE_SIZE);
  localparam int SINE_W       = 12;
  localparam int SIZE_CFG_W   = 11;
  localparam int COUNT_W      = 10;
  localparam int COLOR_W      = 8;
  localparam int CFG_ADDR_W   = 5;
  localparam int CFG_DATA_W   = 32;
  localparam int SUM_W        = SINE_W + 2;

  typedef logic [PHASE_W-1:0]       phase_t;
  typedef logic signed [SINE_W-1:0] sine_t;
  typedef logic [COUNT_W-1:0]       count_t;
  typedef sine_t                    sine_tab_t [TABLE_SIZE];

  // register indexes, one per word of the configuration port
  typedef enum logic [2:0] {
    CfgFrameWidth  = 3'd0,
    CfgFrameHeight = 3'd1,
    CfgColStepA    = 3'd2,
    CfgColStepB    = 3'd3,
    CfgRowStepC    = 3'd4,
    CfgRowStepD    = 3'd5,
    CfgFrameStepA  = 3'd6,
    CfgFrameStepC  = 3'd7
  } cfg_idx_e;

  localparam logic [SIZE_CFG_W-1:0] FrameWidthReset  = 11'd480;
  localparam logic [SIZE_CFG_W-1:0] FrameHeightReset = 11'd360;
  localparam phase_t ColStepAReset   = 9'd5;
  localparam phase_t ColStepBReset   = 9'd3;
  localparam phase_t RowStepCReset   = 9'd1;
  localparam phase_t RowStepDReset   = 9'd3;
  localparam phase_t FrameStepAReset = 9'd9;
  localparam phase_t FrameStepCReset = 9'd8;

  // angles in q61 fixed point
  localparam logic [63:0] PiQ61     = 64'h6487ED5110B4611A;
  localparam logic [63:0] HalfPiQ61 = 64'h3243F6A8885A308D;
  localparam logic [63:0] SineStep  = (64'd50 << 49) + ((64'd4144 << 49) / 64'd15625);
  localparam int          TaylorTerms = 13;
  localparam int          MagShift    = 51;

  // pixel tag carried alongside the colour through the pipe
  typedef struct packed {
    count_t x;
    count_t y;
    logic   eol;
    logic   eof;
  } pix_tag_t;

  function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[124:61];
  endfunction

  // taylor series sine in q61, evaluated once at elaboration
  function automatic sine_tab_t build_sine_table();
    sine_tab_t   tab;
    logic [63:0] th;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] mag;
    logic        neg;
    int          i;
    int          k;
    for (i = 0; i < TABLE_SIZE; i++) begin
      th  = 64'(i) * SineStep;
      neg = 1'b0;
      if (th >= PiQ61) begin
        th  = th - PiQ61;
        neg = 1'b1;
      end
      if (th > HalfPiQ61) begin
        th = PiQ61 - th;
      end
      x2   = mul_q61(th, th);
      term = th;
      sum  = th;
      for (k = 1; k <= TaylorTerms; k++) begin
        term = mul_q61(term, x2) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      mag    = sum >> MagShift;
      tab[i] = neg ? -sine_t'(mag[SINE_W-1:0]) : sine_t'(mag[SINE_W-1:0]);
    end
    return tab;
  endfunction

endpackage

// ----- sv/ppg_sine_rom.sv -----
// two-port sine rom with registered read data
module ppg_sine_rom (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  ppg_pkg::phase_t [1:0]    rd_addr_i,
  output ppg_pkg::sine_t  [1:0]    rd_data_o
);
  import ppg_pkg::*;

  localparam sine_tab_t SineTable = build_sine_table();

  sine_t [1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q[0] <= SineTable[rd_addr_i[0]];
      rd_data_q[1] <= SineTable[rd_addr_i[1]];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/plasma_pattern_generator.sv -----
// top level of the plasma pattern generator: config registers, raster phases and colour pipe
// pipe: phase register, rom read register, result register; an accepted request passes each in turn
// throughput: one pixel per clock while the result is not stalled; stage hand-off lets a
//   request in while a finished result is held
// requests with pixel_tick low are taken and dropped, leaving all state as it was
// reset (rst_ni low, async): pipe empty, raster at column 0 row 0, frame phases zero,
//   config registers back to their default values; rom contents are fixed
module plasma_pattern_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // pixel request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              pixel_tick_i,
  // pixel result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ppg_pkg::COLOR_W-1:0]       color_index_o,
  output logic [ppg_pkg::COUNT_W-1:0]       pixel_x_o,
  output logic [ppg_pkg::COUNT_W-1:0]       pixel_y_o,
  output logic                              end_of_line_o,
  output logic                              end_of_frame_o,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ppg_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [ppg_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [ppg_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import ppg_pkg::*;

  // size compare widths: wide enough for the size register and for the maximum
  localparam int WidthW  = ($clog2(MAX_WIDTH + 1) > SIZE_CFG_W) ?
                           $clog2(MAX_WIDTH + 1) : SIZE_CFG_W;
  localparam int HeightW = ($clog2(MAX_HEIGHT + 1) > SIZE_CFG_W) ?
                           $clog2(MAX_HEIGHT + 1) : SIZE_CFG_W;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [SIZE_CFG_W-1:0] frame_width_q, frame_height_q;
  phase_t                col_step_a_q, col_step_b_q, row_step_c_q, row_step_d_q;
  phase_t                frame_step_a_q, frame_step_c_q;
  logic                  cfg_wr;
  cfg_idx_e              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = cfg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthReset;
      frame_height_q <= FrameHeightReset;
      col_step_a_q   <= ColStepAReset;
      col_step_b_q   <= ColStepBReset;
      row_step_c_q   <= RowStepCReset;
      row_step_d_q   <= RowStepDReset;
      frame_step_a_q <= FrameStepAReset;
      frame_step_c_q <= FrameStepCReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CfgFrameWidth:  frame_width_q  <= pwdata[SIZE_CFG_W-1:0];
        CfgFrameHeight: frame_height_q <= pwdata[SIZE_CFG_W-1:0];
        CfgColStepA:    col_step_a_q   <= pwdata[PHASE_W-1:0];
        CfgColStepB:    col_step_b_q   <= pwdata[PHASE_W-1:0];
        CfgRowStepC:    row_step_c_q   <= pwdata[PHASE_W-1:0];
        CfgRowStepD:    row_step_d_q   <= pwdata[PHASE_W-1:0];
        CfgFrameStepA:  frame_step_a_q <= pwdata[PHASE_W-1:0];
        CfgFrameStepC:  frame_step_c_q <= pwdata[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // read-back, zero extended
  always_comb begin
    unique case (cfg_idx)
      CfgFrameWidth:  prdata = CFG_DATA_W'(frame_width_q);
      CfgFrameHeight: prdata = CFG_DATA_W'(frame_height_q);
      CfgColStepA:    prdata = CFG_DATA_W'(col_step_a_q);
      CfgColStepB:    prdata = CFG_DATA_W'(col_step_b_q);
      CfgRowStepC:    prdata = CFG_DATA_W'(row_step_c_q);
      CfgRowStepD:    prdata = CFG_DATA_W'(row_step_d_q);
      CfgFrameStepA:  prdata = CFG_DATA_W'(frame_step_a_q);
      CfgFrameStepC:  prdata = CFG_DATA_W'(frame_step_c_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // pipe flow control: each stage moves on when the one after it is free or moving
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic en1, en2, en3;
  logic in_acc, pix_step;

  assign en3        = !out_valid_q || !out_stall_i;
  assign en2        = !s2_valid_q || en3;
  assign en1        = !s1_valid_q || en2;
  assign in_stall_o = !en1;
  assign in_acc     = in_valid_i && en1;
  // only a request with the tick set produces a pixel and moves the raster
  assign pix_step   = in_acc && pixel_tick_i;

  // ---------------------------------------------------------------------------
  // raster position and phase state
  // ---------------------------------------------------------------------------
  phase_t base_a_q, base_c_q;
  phase_t run_a_q, run_b_q, run_c_q, run_d_q;
  count_t col_cnt_q, row_cnt_q;

  logic               at_col0, at_frame0;
  phase_t             ph_a, ph_b, ph_c, ph_d;
  logic [WidthW-1:0]  w_lim, col_next;
  logic [HeightW-1:0] h_lim, row_next;
  logic               eol, eof;

  // clamp sizes: zero acts as one, above the maximum saturates
  always_comb begin
    if (frame_width_q == '0) begin
      w_lim = WidthW'(1);
    end else if (WidthW'(frame_width_q) > WidthW'(MAX_WIDTH)) begin
      w_lim = WidthW'(MAX_WIDTH);
    end else begin
      w_lim = WidthW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      h_lim = HeightW'(1);
    end else if (HeightW'(frame_height_q) > HeightW'(MAX_HEIGHT)) begin
      h_lim = HeightW'(MAX_HEIGHT);
    end else begin
      h_lim = HeightW'(frame_height_q);
    end
  end

  // first column of a row restarts a and b from the frame base and the steps;
  // first pixel of a frame also restarts c and d
  assign at_col0   = (col_cnt_q == '0);
  assign at_frame0 = at_col0 && (row_cnt_q == '0);
  assign ph_a      = at_col0 ? phase_t'(base_a_q + col_step_a_q) : run_a_q;
  assign ph_b      = at_col0 ? col_step_b_q : run_b_q;
  assign ph_c      = at_frame0 ? base_c_q : run_c_q;
  assign ph_d      = at_frame0 ? '0 : run_d_q;

  // a shrunk size ends the row or frame at the next pixel, hence >=
  assign col_next = WidthW'(col_cnt_q) + WidthW'(1);
  assign row_next = HeightW'(row_cnt_q) + HeightW'(1);
  assign eol      = (col_next >= w_lim);
  assign eof      = eol && (row_next >= h_lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_a_q  <= '0;
      base_c_q  <= '0;
      run_a_q   <= ColStepAReset;
      run_b_q   <= ColStepBReset;
      run_c_q   <= '0;
      run_d_q   <= '0;
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (pix_step) begin
      run_a_q <= phase_t'(ph_a + col_step_a_q);
      run_b_q <= phase_t'(ph_b + col_step_b_q);
      if (!eol) begin
        col_cnt_q <= col_cnt_q + count_t'(1);
        run_c_q   <= ph_c;
        run_d_q   <= ph_d;
      end else begin
        col_cnt_q <= '0;
        run_c_q   <= phase_t'(ph_c + row_step_c_q);
        run_d_q   <= phase_t'(ph_d + row_step_d_q);
        if (!eof) begin
          row_cnt_q <= row_cnt_q + count_t'(1);
        end else begin
          row_cnt_q <= '0;
          base_a_q  <= phase_t'(base_a_q + frame_step_a_q);
          base_c_q  <= phase_t'(base_c_q + frame_step_c_q);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: rom addresses and pixel tag
  // ---------------------------------------------------------------------------
  phase_t [3:0] s1_ph_q;
  pix_tag_t     s1_tag_q, s2_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en1) begin
      s1_valid_q <= pix_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_ph_q      <= {ph_d, ph_c, ph_b, ph_a};
      s1_tag_q.x   <= col_cnt_q;
      s1_tag_q.y   <= row_cnt_q;
      s1_tag_q.eol <= eol;
      s1_tag_q.eof <= eof;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: four sine lookups, two per rom copy
  // ---------------------------------------------------------------------------
  sine_t [1:0] sin_ab, sin_cd;

  ppg_sine_rom u_rom_ab (
    .clk_i     (clk_i),
    .rd_en_i   (en2),
    .rd_addr_i (s1_ph_q[1:0]),
    .rd_data_o (sin_ab)
  );

  ppg_sine_rom u_rom_cd (
    .clk_i     (clk_i),
    .rd_en_i   (en2),
    .rd_addr_i (s1_ph_q[3:2]),
    .rd_data_o (sin_cd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en2) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_tag_q <= s1_tag_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: sum, floor shift by 4, plus 128 wrapped to 8 bits
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sine_sum;
  logic [COLOR_W-1:0]      color_d, color_q;
  pix_tag_t                out_tag_q;

  assign sine_sum = SUM_W'(sin_ab[0]) + SUM_W'(sin_ab[1]) + SUM_W'(sin_cd[0]) + SUM_W'(sin_cd[1]);
  // low byte of (sum >>> 4) plus 128 is that byte with its top bit flipped
  assign color_d  = {~sine_sum[11], sine_sum[10:4]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en3) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      color_q   <= color_d;
      out_tag_q <= s2_tag_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign color_index_o  = color_q;
  assign pixel_x_o      = out_tag_q.x;
  assign pixel_y_o      = out_tag_q.y;
  assign end_of_line_o  = out_tag_q.eol;
  assign end_of_frame_o = out_tag_q.eof;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // requests are held back only when every stage is full and the result is stalled
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s2_valid_q && out_valid_o && out_stall_i))
    else $error("request stalled with room in the pipe");

  // a frame end is always a line end
  a_eof_implies_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_of_frame_o) |-> end_of_line_o)
    else $error("end of frame without end of line");

  // the column wraps to zero after a line end
  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_step && eol) |=> (col_cnt_q == '0))
    else $error("column did not wrap after line end");

  // a pixel handed on from stage 1 lands in stage 2
  a_s1_to_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && en2) |=> s2_valid_q)
    else $error("pixel lost between address and rom stages");

endmodule
